// File: sv/mcnm_pkg.sv
// Shared types and constants for the marker corner nearest-match block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mcnm_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS     = 11;
  localparam int OUT_W          = COORD_BITS + 2;   // signed predicted corner
  localparam int DX_W           = COORD_BITS + 3;   // signed coordinate difference
  localparam int SQ_W           = 2 * DX_W;         // one squared difference
  localparam int DIST_W         = SQ_W + 1;         // sum of two squares
  localparam int THRESH_W       = 26;
  localparam int INDEX_OUT_W    = 6;
  localparam int CMD_W          = 2;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1500);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } point_t;

  // scan control from the sequencer to each distance unit
  typedef struct packed {
    logic start;   // new query: forget the previous best
    logic valid;   // read data of the point memory is live this cycle
  } scan_ctl_t;

endpackage

`default_nettype wire

// File: sv/mcnm_point_mem.sv
// Candidate point memory: one write port, one synchronous read port.
// Depends on mcnm_pkg (point_t).
`default_nettype none

module mcnm_point_mem #(
  parameter int DEPTH = mcnm_pkg::MAX_POINTS_DEF,
  parameter int AW    = 6
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire mcnm_pkg::point_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output mcnm_pkg::point_t     rdata
);
  import mcnm_pkg::*;

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/mcnm_dist_unit.sv
// Squared-distance stage and running best-match tracker for one predicted corner.
// Depends on mcnm_pkg (point_t, scan_ctl_t, widths).
`default_nettype none

module mcnm_dist_unit #(
  parameter int AW = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mcnm_pkg::scan_ctl_t               ctl,
  input  wire logic [AW-1:0]                     rd_index,
  input  wire mcnm_pkg::point_t                  rd_pt,
  input  wire logic signed [mcnm_pkg::OUT_W-1:0] px,
  input  wire logic signed [mcnm_pkg::OUT_W-1:0] py,
  input  wire logic [mcnm_pkg::THRESH_W-1:0]     thresh,
  output logic                                   busy,
  output logic                                   found,
  output logic [AW-1:0]                          best_index,
  output mcnm_pkg::point_t                       best_pt
);
  import mcnm_pkg::*;

  logic signed [DX_W-1:0] dx;
  logic signed [DX_W-1:0] dy;
  logic signed [SQ_W-1:0] sq_x_c;
  logic signed [SQ_W-1:0] sq_y_c;

  // stage A: registered squares
  logic            a_valid;
  logic [AW-1:0]   a_index;
  point_t          a_pt;
  logic [SQ_W-1:0] sq_x;
  logic [SQ_W-1:0] sq_y;

  logic [DIST_W-1:0] dist_sum;
  logic [DIST_W-1:0] best_dist;
  logic              take;

  assign dx = DX_W'(px) - $signed({2'b00, rd_pt.x});
  assign dy = DX_W'(py) - $signed({2'b00, rd_pt.y});
  assign sq_x_c = dx * dx;
  assign sq_y_c = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    a_index <= rd_index;
    a_pt    <= rd_pt;
    sq_x    <= unsigned'(sq_x_c);
    sq_y    <= unsigned'(sq_y_c);
  end

  // strict compares keep the lowest index on a tie
  assign dist_sum = DIST_W'(sq_x) + DIST_W'(sq_y);
  assign take = a_valid && (dist_sum < DIST_W'(thresh)) && (!found || dist_sum < best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_dist  <= dist_sum;
      best_index <= a_index;
      best_pt    <= a_pt;
    end
  end

  assign busy = a_valid;

endmodule

`default_nettype wire

// File: sv/marker_corner_nearest_match.sv
// Marker corner nearest match: clear and append requests update the list when accepted.
// A query scans all N stored points before its result (an empty list skips the scan);
// the scan reads one point per cycle through the single read port of the point memory.
// One request is in work at a time; a new request is taken while a result waits.
// Reset (synchronous, active high) empties the list, clears the drop flag and sets
// max_dist_sq to 1500; point memory contents are not cleared.
`default_nettype none

module marker_corner_nearest_match #(
  parameter int MAX_POINTS = mcnm_pkg::MAX_POINTS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // configuration
  input  wire logic                                    cfg_wr_en,
  input  wire logic [mcnm_pkg::THRESH_W-1:0]           cfg_wr_data,
  // request channel
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic [mcnm_pkg::CMD_W-1:0]              command,
  input  wire logic [mcnm_pkg::COORD_BITS-1:0]         first_x,
  input  wire logic [mcnm_pkg::COORD_BITS-1:0]         first_y,
  input  wire logic [mcnm_pkg::COORD_BITS-1:0]         second_x,
  input  wire logic [mcnm_pkg::COORD_BITS-1:0]         second_y,
  // result channel
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [mcnm_pkg::OUT_W-1:0]            minus_x,
  output logic signed [mcnm_pkg::OUT_W-1:0]            minus_y,
  output logic signed [mcnm_pkg::OUT_W-1:0]            plus_x,
  output logic signed [mcnm_pkg::OUT_W-1:0]            plus_y,
  output logic                                         minus_found,
  output logic                                         plus_found,
  output logic [mcnm_pkg::INDEX_OUT_W-1:0]             minus_index,
  output logic [mcnm_pkg::INDEX_OUT_W-1:0]             plus_index,
  output logic                                         pair_complete,
  output logic                                         points_dropped
);
  import mcnm_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;   // memory address
  localparam int CW = $clog2(MAX_POINTS + 1);                       // fill count

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,   // one memory read per cycle
    ST_DRAIN  = 4'b0100,   // wait for the read and distance stages to empty
    ST_FINISH = 4'b1000    // load the result register once it is free
  } state_t;

  state_t state;
  state_t state_next;

  logic [THRESH_W-1:0] max_dist_sq;
  logic [CW-1:0]       count;
  logic                overflow;
  logic [CW-1:0]       cnt;        // scan position

  logic   accept;
  cmd_t   cmd;
  logic   mem_we;
  logic   mem_re;
  point_t rd_pt;
  logic   rd_valid;
  logic [AW-1:0] rd_index;
  scan_ctl_t     ctl;
  logic          out_free;

  // predicted corners
  logic signed [OUT_W-1:0] ctr_x, ctr_y, nrm_x, nrm_y;
  logic signed [OUT_W-1:0] pm_x, pm_y, pp_x, pp_y;

  // unit results
  logic          busy_m, busy_p;
  logic          found_m, found_p;
  logic [AW-1:0] idx_m, idx_p;
  point_t        pt_m, pt_p;

  // halve with truncation toward zero
  function automatic logic signed [OUT_W-1:0] half_tz(input logic signed [OUT_W-1:0] v);
    logic signed [OUT_W-1:0] adj;
    adj = v + OUT_W'(v[OUT_W-1]);
    return adj >>> 1;
  endfunction

  assign accept   = in_valid && in_ready;
  assign cmd      = cmd_t'(command);
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // center: sum of two unsigned coordinates is never negative, a shift halves it.
  // normal = ((Cy-Ay)/2, (Ax-Cx)/2)
  always_comb begin
    ctr_x = (OUT_W'(first_x) + OUT_W'(second_x)) >>> 1;
    ctr_y = (OUT_W'(first_y) + OUT_W'(second_y)) >>> 1;
    nrm_x = half_tz(OUT_W'(second_y) - OUT_W'(first_y));
    nrm_y = half_tz(OUT_W'(first_x) - OUT_W'(second_x));
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_QUERY) begin
      pm_x <= ctr_x - nrm_x;
      pm_y <= ctr_y - nrm_y;
      pp_x <= ctr_x + nrm_x;
      pp_y <= ctr_y + nrm_y;
    end
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist_sq <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      max_dist_sq <= cfg_wr_data;
    end
  end

  // list fill count and drop flag; an append on a full list only sets the flag
  assign mem_we = accept && cmd == CMD_APPEND && count < CW'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      unique case (cmd)
        CMD_CLEAR: begin
          count    <= '0;
          overflow <= 1'b0;
        end
        CMD_APPEND: begin
          if (count < CW'(MAX_POINTS)) begin
            count <= count + CW'(1);
          end else begin
            overflow <= 1'b1;
          end
        end
        CMD_QUERY, CMD_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_QUERY) begin
          state_next = (count == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt + CW'(1) == count) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !busy_m && !busy_p) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + CW'(1);
    end
  end

  assign mem_re = (state == ST_SCAN);

  // read tag travels beside the memory's registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    rd_index <= cnt[AW-1:0];
  end

  assign ctl.start = accept && cmd == CMD_QUERY;
  assign ctl.valid = rd_valid;

  mcnm_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[AW-1:0]),
    .wdata ({first_y, first_x}),
    .re    (mem_re),
    .raddr (cnt[AW-1:0]),
    .rdata (rd_pt)
  );

  mcnm_dist_unit #(
    .AW (AW)
  ) u_minus (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rd_index   (rd_index),
    .rd_pt      (rd_pt),
    .px         (pm_x),
    .py         (pm_y),
    .thresh     (max_dist_sq),
    .busy       (busy_m),
    .found      (found_m),
    .best_index (idx_m),
    .best_pt    (pt_m)
  );

  mcnm_dist_unit #(
    .AW (AW)
  ) u_plus (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rd_index   (rd_index),
    .rd_pt      (rd_pt),
    .px         (pp_x),
    .py         (pp_y),
    .thresh     (max_dist_sq),
    .busy       (busy_p),
    .found      (found_p),
    .best_index (idx_p),
    .best_pt    (pt_p)
  );

  // result register; a miss reports the prediction and index zero
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      minus_x        <= found_m ? OUT_W'(pt_m.x) : pm_x;
      minus_y        <= found_m ? OUT_W'(pt_m.y) : pm_y;
      plus_x         <= found_p ? OUT_W'(pt_p.x) : pp_x;
      plus_y         <= found_p ? OUT_W'(pt_p.y) : pp_y;
      minus_found    <= found_m;
      plus_found     <= found_p;
      minus_index    <= found_m ? INDEX_OUT_W'(idx_m) : '0;
      plus_index     <= found_p ? INDEX_OUT_W'(idx_p) : '0;
      pair_complete  <= found_m && found_p;
      points_dropped <= overflow;
    end
  end

  // the scan never reads at or beyond the fill count
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> cnt < count)
    else $error("scan address beyond fill count");

  // the fill count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("fill count above capacity");

  // a dropped point means the list is full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> count == CW'(MAX_POINTS))
    else $error("drop flag set on a list that is not full");

  // a new result only comes out of the finish step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside the finish step");

  // no read data is in flight once the sequencer leaves drain
  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |-> !rd_valid && !busy_m && !busy_p)
    else $error("distance pipeline not empty at finish");

endmodule

`default_nettype wire
